[design/cms_pkg.sv]
package cms_pkg;

  localparam int LIMB = 32;
  localparam int SKEW_MIN_N = 5;
  localparam int SKEW_POWER = 3;
  localparam int KURT_POWER = 4;
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAG = 32'h8000_0000;
  localparam logic [31:0] KURT_BIAS = 32'd196608;
  localparam logic [31:0] KURT_LIM = 32'h8002_ffff;

  localparam logic CFG_USE_GIVEN = 1'b0;
  localparam logic CFG_GIVEN_MEAN = 1'b1;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] mean_value;
    logic [31:0]        std_dev;
    logic signed [31:0] skewness;
    logic signed [31:0] kurtosis;
    logic [10:0]        sample_total;
    logic               zero_variance;
    logic               samples_dropped;
    logic               saturated;
  } out_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_MEAN_GIVEN,
    DP_MEAN_START,
    DP_MEAN_TAKE,
    DP_RD,
    DP_DEV,
    DP_ACC2,
    DP_ACC3,
    DP_ACC4,
    DP_VAR_START,
    DP_SQRT_START,
    DP_NUM_SK,
    DP_NUM_TAKE_SK,
    DP_NUM_TAKE_K,
    DP_DEN_S,
    DP_DIV_START,
    DP_SKEW_SET,
    DP_KURT_SET,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic use_given;
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic pass_done;
    logic s_zero;
  } stat_t;

endpackage

[design/cms_mulw.sv]
module cms_mulw #(
  parameter int WL = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [WL*32-1:0]    x,
  input  logic [31:0]         m,
  output logic [WL*32-1:0]    p,
  output logic                done
);
  import cms_pkg::*;

  localparam int WW = WL * LIMB;
  localparam int CNTW = $clog2(WL + 1);

  logic [WW-1:0]   xr;
  logic [31:0]     mr;
  logic [31:0]     carry;
  logic [CNTW-1:0] cnt;
  logic            run;
  logic [63:0]     prod;

  assign prod = 64'(xr[31:0]) * 64'(mr) + 64'(carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xr    <= x;
        mr    <= m;
        carry <= '0;
        cnt   <= '0;
        run   <= 1'b1;
      end else if (run) begin
        p     <= {prod[31:0], p[WW-1:32]};
        xr    <= {32'd0, xr[WW-1:32]};
        carry <= prod[63:32];
        cnt   <= cnt + 1'b1;
        if (cnt == CNTW'(WL - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/cms_div.sv]
module cms_div #(
  parameter int WW = 160
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [WW-1:0] num,
  input  logic [WW-1:0] den,
  output logic [WW-1:0] q,
  output logic          done
);
  import cms_pkg::*;

  localparam int CNTW = $clog2(WW);

  logic [WW-1:0]   nr;
  logic [WW-1:0]   dr;
  logic [WW-1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic            run;
  logic [WW:0]     r2;
  logic [WW:0]     diff;
  logic            ge;

  assign r2   = {rem, nr[WW-1]};
  assign diff = r2 - {1'b0, dr};
  assign ge   = r2 >= {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nr  <= num;
        dr  <= den;
        rem <= '0;
        q   <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? diff[WW-1:0] : r2[WW-1:0];
        q   <= {q[WW-2:0], ge};
        nr  <= {nr[WW-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(WW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/cms_datapath.sv]
module cms_datapath #(
  parameter int MAX_SAMPLES = 1024,
  parameter int CW = 11,
  parameter int WL = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  cms_pkg::cmd_t      cmd,
  input  logic signed [31:0] sample,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output cms_pkg::stat_t     stat,
  output cms_pkg::out_t      result,
  output logic               done
);
  import cms_pkg::*;

  localparam int WW = WL * LIMB;
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int SW = 32 + CW;

  logic               use_given;
  logic signed [31:0] given_mean;

  logic [31:0]        store [MAX_SAMPLES];
  logic signed [31:0] rdata;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic signed [SW-1:0] sum;
  logic               ovf;

  logic signed [31:0] mean;
  logic [31:0]        a_r;
  logic               dneg_r;
  logic [WW-1:0]      s2;
  logic [WW-1:0]      s3;
  logic [WW-1:0]      s4;
  logic [WW-1:0]      num;
  logic               skneg;
  logic signed [31:0] skew;
  logic signed [31:0] kurt;
  logic               sat;

  logic [63:0]        sq_src;
  logic [34:0]        sq_rem;
  logic [31:0]        sq_root;
  logic [4:0]         sq_cnt;
  logic               sq_run;
  logic               sqrt_done;
  logic [34:0]        rem_sh;
  logic [34:0]        trial;
  logic               sq_ge;

  logic               mul_start;
  logic [WW-1:0]      mul_x;
  logic [31:0]        mul_m;
  logic [WW-1:0]      mul_p;
  logic               mul_done;
  logic               div_start;
  logic [WW-1:0]      div_num;
  logic [WW-1:0]      div_den;
  logic [WW-1:0]      div_q;
  logic               div_done;

  logic               room;
  logic               ngt5;
  logic [31:0]        n32;
  logic [SW-1:0]      sum_neg_v;
  logic [SW-1:0]      sum_mag;
  logic signed [32:0] dev_d;
  logic [32:0]        dev_neg_v;
  logic [31:0]        dev_a;
  logic [WW-1:0]      s3_neg_v;
  logic [WW-1:0]      s3_mag;
  logic [31:0]        q32;

  assign room      = count < CW'(MAX_SAMPLES);
  assign ngt5      = count > CW'(SKEW_MIN_N);
  assign n32       = 32'(count);
  assign sum_neg_v = -sum;
  assign sum_mag   = sum[SW-1] ? sum_neg_v : sum;
  assign dev_d     = 33'(rdata) - 33'(mean);
  assign dev_neg_v = -dev_d;
  assign dev_a     = dev_d[32] ? dev_neg_v[31:0] : dev_d[31:0];
  assign s3_neg_v  = -s3;
  assign s3_mag    = s3[WW-1] ? s3_neg_v : s3;
  assign q32       = div_q[31:0];

  assign rem_sh = {sq_rem[32:0], sq_src[63:62]};
  assign trial  = {1'b0, sq_root, 2'b01};
  assign sq_ge  = rem_sh >= trial;

  assign stat.use_given = use_given;
  assign stat.mul_done  = mul_done;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.pass_done = idx == count;
  assign stat.s_zero    = sq_root == 32'd0;

  always_comb begin
    mul_start = 1'b0;
    mul_x     = '0;
    mul_m     = '0;
    div_start = 1'b0;
    div_num   = num;
    div_den   = mul_p;
    case (cmd.op)
      DP_DEV: begin
        mul_start = 1'b1;
        mul_x     = WW'(dev_a);
        mul_m     = dev_a;
      end
      DP_ACC2, DP_ACC3: begin
        mul_start = 1'b1;
        mul_x     = mul_p;
        mul_m     = a_r;
      end
      DP_NUM_SK: begin
        mul_start = 1'b1;
        mul_x     = s3_mag << 16;
        mul_m     = ngt5 ? n32 : 32'd1;
      end
      DP_NUM_TAKE_SK: begin
        mul_start = 1'b1;
        mul_x     = WW'(ngt5 ? n32 - 32'd1 : n32);
        mul_m     = ngt5 ? n32 - 32'd2 : 32'd1;
      end
      DP_DEN_S: begin
        mul_start = 1'b1;
        mul_x     = mul_p;
        mul_m     = sq_root;
      end
      DP_SKEW_SET: begin
        mul_start = 1'b1;
        mul_x     = s4 << 16;
        mul_m     = 32'd1;
      end
      DP_NUM_TAKE_K: begin
        mul_start = 1'b1;
        mul_x     = WW'(n32);
        mul_m     = 32'd1;
      end
      DP_MEAN_START: begin
        div_start = 1'b1;
        div_num   = WW'(sum_mag);
        div_den   = WW'(count);
      end
      DP_VAR_START: begin
        div_start = 1'b1;
        div_num   = s2;
        div_den   = WW'(count);
      end
      DP_DIV_START: begin
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  cms_mulw #(.WL(WL)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .x(mul_x), .m(mul_m),
    .p(mul_p), .done(mul_done)
  );

  cms_div #(.WW(WW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .q(div_q), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      use_given  <= 1'b0;
      given_mean <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_USE_GIVEN:  use_given  <= cfg_data[0];
        CFG_GIVEN_MEAN: given_mean <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD && room) store[count[AW-1:0]] <= sample;
    if (cmd.op == DP_RD) rdata <= store[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum       <= '0;
      ovf       <= 1'b0;
      sq_run    <= 1'b0;
      sqrt_done <= 1'b0;
      done      <= 1'b0;
    end else begin
      done      <= 1'b0;
      sqrt_done <= 1'b0;
      if (sq_run) begin
        sq_rem  <= sq_ge ? rem_sh - trial : rem_sh;
        sq_root <= {sq_root[30:0], sq_ge};
        sq_src  <= {sq_src[61:0], 2'b00};
        sq_cnt  <= sq_cnt + 1'b1;
        if (sq_cnt == 5'd31) begin
          sq_run    <= 1'b0;
          sqrt_done <= 1'b1;
        end
      end
      case (cmd.op)
        DP_LOAD: begin
          if (room) begin
            sum   <= sum + SW'(sample);
            count <= count + 1'b1;
          end else begin
            ovf <= 1'b1;
          end
        end
        DP_MEAN_GIVEN, DP_MEAN_TAKE: begin
          mean <= (cmd.op == DP_MEAN_GIVEN) ? given_mean
                  : (sum[SW-1] ? -q32 : q32);
          idx  <= '0;
          s2   <= '0;
          s3   <= '0;
          s4   <= '0;
        end
        DP_DEV: begin
          a_r    <= dev_a;
          dneg_r <= dev_d[32];
        end
        DP_ACC2: s2 <= s2 + mul_p;
        DP_ACC3: s3 <= dneg_r ? s3 - mul_p : s3 + mul_p;
        DP_ACC4: begin
          s4  <= s4 + mul_p;
          idx <= idx + 1'b1;
        end
        DP_SQRT_START: begin
          sq_src  <= div_q[63:0];
          sq_rem  <= '0;
          sq_root <= '0;
          sq_cnt  <= '0;
          sq_run  <= 1'b1;
          skew    <= '0;
          kurt    <= '0;
          sat     <= 1'b0;
        end
        DP_NUM_SK: skneg <= s3[WW-1];
        DP_NUM_TAKE_SK, DP_NUM_TAKE_K: num <= mul_p;
        DP_SKEW_SET: begin
          if (div_q > WW'(skneg ? NEG_MAG : POS_MAX)) begin
            sat  <= 1'b1;
            skew <= skneg ? NEG_MAG : POS_MAX;
          end else begin
            skew <= skneg ? -q32 : q32;
          end
        end
        DP_KURT_SET: begin
          if (div_q > WW'(KURT_LIM)) begin
            sat  <= 1'b1;
            kurt <= POS_MAX;
          end else begin
            kurt <= q32 - KURT_BIAS;
          end
        end
        DP_EMIT: begin
          result.mean_value      <= mean;
          result.std_dev         <= sq_root;
          result.skewness        <= skew;
          result.kurtosis        <= kurt;
          result.sample_total    <= 11'(count);
          result.zero_variance   <= sq_root == 32'd0;
          result.samples_dropped <= ovf;
          result.saturated       <= sat;
          done  <= 1'b1;
          count <= '0;
          sum   <= '0;
          ovf   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

[design/cms_ctrl.sv]
module cms_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last,
  input  cms_pkg::stat_t stat,
  output cms_pkg::cmd_t  cmd,
  output logic           busy
);
  import cms_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_PRE  = 14'b00000000000010,
    S_MEAN = 14'b00000000000100,
    S_RD   = 14'b00000000001000,
    S_DEV  = 14'b00000000010000,
    S_M2   = 14'b00000000100000,
    S_M3   = 14'b00000001000000,
    S_M4   = 14'b00000010000000,
    S_VAR  = 14'b00000100000000,
    S_SQRT = 14'b00001000000000,
    S_NUM  = 14'b00010000000000,
    S_DEN  = 14'b00100000000000,
    S_DIV  = 14'b01000000000000,
    S_EMIT = 14'b10000000000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] k, k_next;
  logic       kph, kph_next;

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    k_next     = k;
    kph_next   = kph;
    cmd.op     = DP_NOP;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = DP_LOAD;
          if (last) state_next = S_PRE;
        end
      end
      S_PRE: begin
        if (stat.use_given) begin
          cmd.op     = DP_MEAN_GIVEN;
          state_next = S_RD;
        end else begin
          cmd.op     = DP_MEAN_START;
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        if (stat.div_done) begin
          cmd.op     = DP_MEAN_TAKE;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (stat.pass_done) begin
          cmd.op     = DP_VAR_START;
          state_next = S_VAR;
        end else begin
          cmd.op     = DP_RD;
          state_next = S_DEV;
        end
      end
      S_DEV: begin
        cmd.op     = DP_DEV;
        state_next = S_M2;
      end
      S_M2: begin
        if (stat.mul_done) begin
          cmd.op     = DP_ACC2;
          state_next = S_M3;
        end
      end
      S_M3: begin
        if (stat.mul_done) begin
          cmd.op     = DP_ACC3;
          state_next = S_M4;
        end
      end
      S_M4: begin
        if (stat.mul_done) begin
          cmd.op     = DP_ACC4;
          state_next = S_RD;
        end
      end
      S_VAR: begin
        if (stat.div_done) begin
          cmd.op     = DP_SQRT_START;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          if (stat.s_zero) begin
            state_next = S_EMIT;
          end else begin
            cmd.op     = DP_NUM_SK;
            kph_next   = 1'b0;
            state_next = S_NUM;
          end
        end
      end
      S_NUM: begin
        if (stat.mul_done) begin
          cmd.op     = kph ? DP_NUM_TAKE_K : DP_NUM_TAKE_SK;
          k_next     = kph ? 3'(KURT_POWER) : 3'(SKEW_POWER);
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        if (stat.mul_done) begin
          if (k != 3'd0) begin
            cmd.op = DP_DEN_S;
            k_next = k - 3'd1;
          end else begin
            cmd.op     = DP_DIV_START;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (kph) begin
            cmd.op     = DP_KURT_SET;
            state_next = S_EMIT;
          end else begin
            cmd.op     = DP_SKEW_SET;
            kph_next   = 1'b1;
            state_next = S_NUM;
          end
        end
      end
      S_EMIT: begin
        cmd.op     = DP_EMIT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      kph   <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      kph   <= kph_next;
    end
  end

endmodule

[design/central_moments_stats_top.sv]
// Samples are taken one per cycle while busy is low; the sample marked last
// ends the set and raises busy. The block then works alone: with WL 32-bit
// limbs in the wide sums (WL = ceil((144 + count bits) / 32), 5 at the
// default depth), the mean is found by a divide when it is computed, each
// stored sample is read back and its deviation raised to powers through the
// limb-serial multiplier, the variance is divided out and its square root
// taken, and, when that root is nonzero, skewness and kurtosis take two more
// divides plus eleven multiplies on the restoring divider and the 32x32 limb
// multiplier. The result shows on result, marked by done, high for a single
// cycle; the receiver cannot stall it; busy is low again in that same cycle.
module central_moments_stats_top #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cms_pkg::in_t  item,
  output cms_pkg::out_t result,
  output logic          done,
  input  logic          cfg_write,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);
  import cms_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int WL = (144 + CW + LIMB - 1) / LIMB;

  cmd_t  cmd;
  stat_t stat;

  cms_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last(item.last), .stat(stat),
    .cmd(cmd), .busy(busy)
  );

  cms_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .WL(WL)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sample(item.sample),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .stat(stat), .result(result), .done(done)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_load_stays_ready: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !item.last) |=> !busy) else $error("busy after plain transfer");

  a_last_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last) |=> busy) else $error("last transfer did not start work");

endmodule
